/* hdl/ntb_port_window_and_irq_registers_assert.svh */
// Assertion macros for the bridge port register block.
`ifndef NTB_PORT_WINDOW_AND_IRQ_REGISTERS_ASSERT_SVH
`define NTB_PORT_WINDOW_AND_IRQ_REGISTERS_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset.
`define NTBPW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet in reset.
`define NTBPW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ntbpw_pkg.sv */
// Types and constants of the bridge port window and interrupt register block.
`timescale 1ns / 1ps
`default_nettype none
package ntbpw_pkg;

   localparam int NUM_SETUP = 5;
   localparam int NUM_TRANS = 4;

   // Transaction opcodes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_XLATE = 2'd2;

   // Register selectors
   localparam logic [3:0] SEL_TRANS_BASE = 4'd5;
   localparam logic [3:0] SEL_REQ_SET    = 4'd9;
   localparam logic [3:0] SEL_REQ_CLR    = 4'd10;
   localparam logic [3:0] SEL_MASK_SET   = 4'd11;
   localparam logic [3:0] SEL_MASK_CLR   = 4'd12;

   // Configuration register indexes
   localparam logic [1:0] CSR_LINK_MODE = 2'd0;
   localparam logic [1:0] CSR_MSI_MODE  = 2'd1;

   // Write masks, element i for word i
   localparam logic [NUM_SETUP-1:0][31:0] SETUP_WRITABLE = {
      32'hffff_ffff, 32'hfff0_000e, 32'hffff_ffff, 32'hfff0_000e, 32'h0000_0003
   };
   localparam logic [NUM_TRANS-1:0][31:0] TRANS_WRITABLE = {
      32'hffff_ffff, 32'hfff0_0000, 32'hffff_ffff, 32'hfff0_0000
   };

   localparam logic [31:0] SETUP0_RESET  = 32'h0000_0002;
   localparam logic [15:0] MASK_RESET    = 16'hffff;
   localparam logic [53:0] WIN0_SIZE_KIB = 54'd128;   // 128 * 1024 bytes
   localparam logic [43:0] SIZE64_TOP    = 44'h800_0000_0000;  // 2^43 MiB
   localparam logic [11:0] SIZE32_TOP    = 12'd2048;           // MiB

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  reg_sel;
      logic [31:0] write_data;
      logic [2:0]  window_num;
      logic [63:0] window_offset;
   } ntbpw_req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
      logic        msi_pulse;
      logic [63:0] out_address;
      logic        win_enabled;
      logic        win_is64;
      logic        win_prefetch;
      logic [53:0] win_size_kib;
      logic        access_blocked;
   } ntbpw_rsp_type;

   // 32-bit window size in KiB from bits 30:20
   function automatic logic [53:0] size32_kib(input logic [31:0] word);
      logic [11:0] mib;
      mib = SIZE32_TOP - {1'b0, word[30:20]};
      return {32'd0, mib, 10'd0};
   endfunction

   // 64-bit window size in KiB from a setup word pair
   function automatic logic [53:0] size64_kib(input logic [31:0] lo, input logic [31:0] hi);
      logic [43:0] mib;
      mib = SIZE64_TOP - {1'b0, hi[30:0], lo[31:20]};
      return {mib, 10'd0};
   endfunction

endpackage
`default_nettype wire

/* hdl/ntb_port_window_and_irq_registers.sv */
// An accepted request transaction passes the input register and then the response
// register. Throughput: one transaction per cycle when no stall holds the flow; the two
// registers part the two sides, with stall passed back through one stage.
// Reset (synchronous, active high) empties both stages, loads setup word 0
// with 2, clears the rest and the request bits, and sets all mask bits.
`timescale 1ns / 1ps
`default_nettype none
module ntb_port_window_and_irq_registers
   import ntbpw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   // request channel
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire ntbpw_req_type req_payload,
   // response channel
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output ntbpw_rsp_type      rsp_payload,
   // configuration writes
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [0:0]    csr_wdata
);

`include "ntb_port_window_and_irq_registers_assert.svh"

   // ------------------------------------------------------------------
   // Pipeline control
   // ------------------------------------------------------------------
   logic          s1_vld_ff, s1_vld_in;
   ntbpw_req_type s1_req_ff;
   logic          rsp_vld_ff, rsp_vld_in;
   ntbpw_rsp_type rsp_ff, rsp_in;
   logic          s1_adv;   // stage 1 transaction commits and moves to output
   logic          req_take;

   assign s1_adv    = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;
   assign s1_vld_in = req_take || (s1_vld_ff && !s1_adv);
   assign rsp_vld_in = s1_adv || (rsp_vld_ff && rsp_stall);

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      if (req_take) begin
         s1_req_ff <= req_payload;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // ------------------------------------------------------------------
   // Configuration: always ready, index beyond the list ignored
   // ------------------------------------------------------------------
   logic link_mode_ff, msi_mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_mode_ff <= 1'b0;
         msi_mode_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_LINK_MODE) begin
            link_mode_ff <= csr_wdata[0];
         end
         if (csr_index == CSR_MSI_MODE) begin
            msi_mode_ff <= csr_wdata[0];
         end
      end
   end

   // ------------------------------------------------------------------
   // Register state
   // ------------------------------------------------------------------
   logic [31:0] setup_ff [NUM_SETUP];
   logic [31:0] setup_in [NUM_SETUP];
   logic [31:0] trans_ff [NUM_TRANS];
   logic [31:0] trans_in [NUM_TRANS];
   logic [15:0] request_ff, request_in;
   logic [15:0] mask_ff, mask_in;
   logic [15:0] prev_pending_ff, prev_pending_in;

   logic        is_write, irq_wr;
   logic [15:0] irq_d, pend_new;
   logic        risen;

   assign is_write = s1_req_ff.op == OP_WRITE;
   assign irq_wr   = is_write && (s1_req_ff.reg_sel >= SEL_REQ_SET)
                     && (s1_req_ff.reg_sel <= SEL_MASK_CLR);
   assign irq_d    = s1_req_ff.write_data[15:0];

   always_comb begin
      for (int i = 0; i < NUM_SETUP; i++) begin
         setup_in[i] = setup_ff[i];
         if (is_write && s1_req_ff.reg_sel == 4'(i)) begin
            setup_in[i] = (setup_ff[i] & ~SETUP_WRITABLE[i])
                        | (s1_req_ff.write_data & SETUP_WRITABLE[i]);
         end
      end
      for (int k = 0; k < NUM_TRANS; k++) begin
         trans_in[k] = trans_ff[k];
         if (is_write && s1_req_ff.reg_sel == SEL_TRANS_BASE + 4'(k)) begin
            trans_in[k] = (trans_ff[k] & ~TRANS_WRITABLE[k])
                        | (s1_req_ff.write_data & TRANS_WRITABLE[k]);
         end
      end

      request_in = request_ff;
      mask_in    = mask_ff;
      if (irq_wr) begin
         unique case (s1_req_ff.reg_sel)
            SEL_REQ_SET:  request_in = request_ff | irq_d;
            SEL_REQ_CLR:  request_in = request_ff & ~irq_d;
            SEL_MASK_SET: mask_in    = mask_ff | irq_d;
            default:      mask_in    = mask_ff & ~irq_d;
         endcase
      end
      pend_new        = request_in & ~mask_in;
      risen           = |(pend_new & ~prev_pending_ff);
      prev_pending_in = irq_wr ? pend_new : prev_pending_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SETUP; i++) begin
            setup_ff[i] <= (i == 0) ? SETUP0_RESET : 32'd0;
         end
         for (int k = 0; k < NUM_TRANS; k++) begin
            trans_ff[k] <= 32'd0;
         end
         request_ff      <= 16'd0;
         mask_ff         <= MASK_RESET;
         prev_pending_ff <= 16'd0;
      end else if (s1_adv) begin
         setup_ff        <= setup_in;
         trans_ff        <= trans_in;
         request_ff      <= request_in;
         mask_ff         <= mask_in;
         prev_pending_ff <= prev_pending_in;
      end
   end

   // ------------------------------------------------------------------
   // Register read
   // ------------------------------------------------------------------
   logic [31:0] rd_word;

   always_comb begin
      unique case (s1_req_ff.reg_sel)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4:
            rd_word = setup_ff[s1_req_ff.reg_sel[2:0]];
         4'd5, 4'd6, 4'd7, 4'd8:
            rd_word = trans_ff[2'(s1_req_ff.reg_sel - SEL_TRANS_BASE)];
         SEL_REQ_SET, SEL_REQ_CLR:
            rd_word = {16'd0, request_ff};
         SEL_MASK_SET, SEL_MASK_CLR:
            rd_word = {16'd0, mask_ff};
         default:
            rd_word = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Window decode: every window decoded at its fixed words, then one
   // selected and a single offset add done
   // ------------------------------------------------------------------
   logic        w_en   [NUM_SETUP];
   logic        w_is64 [NUM_SETUP];
   logic        w_pref [NUM_SETUP];
   logic [53:0] w_kib  [NUM_SETUP];
   logic [32:0] w_add  [NUM_SETUP];

   always_comb begin
      // window 0: type in bits 1:0, fixed size, no translation
      w_en[0]   = setup_ff[0][1];
      w_is64[0] = 1'b0;
      w_pref[0] = setup_ff[0][2];
      w_kib[0]  = setup_ff[0][1] ? WIN0_SIZE_KIB : 54'd0;
      w_add[0]  = 33'd0;

      // windows 1 and 3: 32-bit, or 64-bit paired with the next word
      for (int w = 1; w < NUM_SETUP; w += 2) begin
         w_is64[w] = setup_ff[w][2];
         w_pref[w] = setup_ff[w][3];
         w_en[w]   = 1'b0;
         w_kib[w]  = 54'd0;
         if (setup_ff[w][2:1] == 2'd0) begin
            w_en[w] = setup_ff[w][31];
            if (setup_ff[w][31]) begin
               w_kib[w] = size32_kib(setup_ff[w]);
            end
         end else if (setup_ff[w][2:1] == 2'd2) begin
            w_en[w] = setup_ff[w+1][31];
            if (setup_ff[w+1][31]) begin
               w_kib[w] = size64_kib(setup_ff[w], setup_ff[w+1]);
            end
         end
         w_add[w] = {1'b0, trans_ff[w-1]}
                  + (setup_ff[w][2] ? {1'b0, trans_ff[w]} : 33'd0);
      end

      // windows 2 and 4: 32-bit only while the window below is 32-bit too
      for (int w = 2; w < NUM_SETUP; w += 2) begin
         w_is64[w] = 1'b0;
         w_pref[w] = setup_ff[w][3];
         w_en[w]   = (setup_ff[w][2:1] == 2'd0) && (setup_ff[w-1][2:1] == 2'd0)
                     && setup_ff[w][31];
         w_kib[w]  = w_en[w] ? size32_kib(setup_ff[w]) : 54'd0;
         w_add[w]  = {1'b0, trans_ff[w-1]};
      end
   end

   logic        win_ok;
   logic [2:0]  win_idx;
   logic [32:0] sel_add;

   assign win_ok  = s1_req_ff.window_num < 3'(NUM_SETUP);
   assign win_idx = s1_req_ff.window_num;
   assign sel_add = win_ok ? w_add[win_idx] : 33'd0;

   // ------------------------------------------------------------------
   // Response build
   // ------------------------------------------------------------------
   always_comb begin
      rsp_in = '0;
      unique case (s1_req_ff.op)
         OP_WRITE: begin
            rsp_in.msi_pulse = irq_wr && risen && msi_mode_ff;
         end
         OP_READ: begin
            rsp_in.read_data = rd_word;
         end
         OP_XLATE: begin
            rsp_in.out_address = s1_req_ff.window_offset + {31'd0, sel_add};
            if (win_ok) begin
               rsp_in.win_enabled    = w_en[win_idx];
               rsp_in.win_is64       = w_is64[win_idx];
               rsp_in.win_prefetch   = w_pref[win_idx];
               rsp_in.win_size_kib   = w_kib[win_idx];
               rsp_in.access_blocked = (win_idx == 3'd0) && !link_mode_ff;
            end
         end
         default: begin
         end
      endcase
      // line level follows pending as left by this transaction
      rsp_in.irq_level = !msi_mode_ff && (|prev_pending_in);
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `NTBPW_ASSERT_NOW(a_pending_tracks, 1'b1, prev_pending_ff == (request_ff & ~mask_ff), "pending copy out of step with request and mask")
   `NTBPW_ASSERT_NOW(a_irq_exclusive, rsp_vld_ff, !(rsp_ff.msi_pulse && rsp_ff.irq_level), "message pulse and level line raised together")
   `NTBPW_ASSERT_NEXT(a_state_hold, !s1_adv, $stable(request_ff) && $stable(mask_ff), "interrupt state changed without a committed transaction")

endmodule
`default_nettype wire
